/* hw/rtl/firmware_image_receive_sequencer_defines.svh */
// ----------------------------------------------------------------------------
// firmware_image_receive_sequencer_defines: assertion macros
// Shared property macros for the receive sequencer checkers.
// ----------------------------------------------------------------------------
`ifndef FIRMWARE_IMAGE_RECEIVE_SEQUENCER_DEFINES_SVH
`define FIRMWARE_IMAGE_RECEIVE_SEQUENCER_DEFINES_SVH

// same-cycle implication, held off during reset
`define FWRX_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: property failed");

// next-cycle implication, held off during reset
`define FWRX_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: property failed");

`endif

/* hw/rtl/fwrx_pkg.sv */
// ----------------------------------------------------------------------------
// fwrx_pkg: receive sequencer types and constants
// Event kinds, status codes, writer actions and controller/datapath links.
// ----------------------------------------------------------------------------
package fwrx_pkg;

	// largest chunk payload in bytes
	localparam int unsigned CHUNK_MAX_BYTES = 128;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_IMAGE_BYTES = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_INACT_TIMEOUT   = 1'b1;

	// reset values of the configuration registers
	localparam logic [31:0] MAX_IMAGE_RST = 32'd1048576;
	localparam logic [31:0] TIMEOUT_RST   = 32'd10000;

	// event kinds
	localparam logic [2:0] KIND_BEGIN  = 3'd0;
	localparam logic [2:0] KIND_CHUNK  = 3'd1;
	localparam logic [2:0] KIND_FINISH = 3'd2;
	localparam logic [2:0] KIND_TICK   = 3'd3;
	localparam logic [2:0] KIND_DISC   = 3'd4;

	// writer commit results
	localparam logic [1:0] COMMIT_OK   = 2'd0;
	localparam logic [1:0] COMMIT_HASH = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE      = 3'd0,
		ST_RECEIVING = 3'd1,
		ST_VERIFYING = 3'd2,
		ST_READY     = 3'd3,
		ST_FAILED    = 3'd4
	} upd_state_t;

	typedef enum logic [3:0] {
		ER_NONE        = 4'd0,
		ER_BUSY        = 4'd1,
		ER_TOO_LARGE   = 4'd2,
		ER_INVALID     = 4'd3,
		ER_WRITE       = 4'd4,
		ER_NOT_STARTED = 4'd5,
		ER_OFFSET      = 4'd6,
		ER_HASH        = 4'd7,
		ER_TIMEOUT     = 4'd8,
		ER_LINK        = 4'd9
	} err_t;

	typedef enum logic [2:0] {
		ACT_NONE   = 3'd0,
		ACT_BEGIN  = 3'd1,
		ACT_WRITE  = 3'd2,
		ACT_COMMIT = 3'd3,
		ACT_ABORT  = 3'd4
	} act_t;

	// datapath to controller: decoded conditions of the captured event
	typedef struct packed {
		logic [2:0] kind;
		logic       active;
		logic       size_zero;
		logic       size_big;
		logic       same_begin;
		logic       len_bad;
		logic       end_bad;
		logic       dup;
		logic       off_eq;
		logic       off_done;
		logic       timed_out;
		logic       wok;
		logic [1:0] commit;
		logic       res_free;
	} fwrx_sts_t;

	// controller to datapath: load and update strobes
	typedef struct packed {
		logic       capture;
		logic       exec;
		logic       acc;
		act_t       act;
		logic       set_state;
		upd_state_t state;
		logic       set_error;
		err_t       error;
		logic       load_size;
		logic       clr_offset;
		logic       adv_offset;
		logic       load_hash;
		logic       touch;
		logic       set_active;
		logic       active;
		logic       set_restart;
		logic       restart;
	} fwrx_cmd_t;

endpackage

/* hw/rtl/fwrx_ifs.sv */
// ----------------------------------------------------------------------------
// fwrx_ifs: event and result channels
// Valid/ready channels carrying one event beat in and one result beat out.
// ----------------------------------------------------------------------------
interface fwrx_evt_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [31:0] now_ms;
	logic [31:0] image_size;
	logic [63:0] hash_word0;
	logic [63:0] hash_word1;
	logic [63:0] hash_word2;
	logic [63:0] hash_word3;
	logic [31:0] chunk_offset;
	logic [15:0] chunk_length;
	logic        writer_ok;
	logic [1:0]  commit_result;

	modport source (
		output valid, kind, now_ms, image_size, hash_word0, hash_word1, hash_word2,
			hash_word3, chunk_offset, chunk_length, writer_ok, commit_result,
		input  ready
	);
	modport sink (
		input  valid, kind, now_ms, image_size, hash_word0, hash_word1, hash_word2,
			hash_word3, chunk_offset, chunk_length, writer_ok, commit_result,
		output ready
	);
endinterface

interface fwrx_res_if;
	logic        valid;
	logic        ready;
	logic        accepted;
	logic [2:0]  update_state;
	logic [3:0]  error_code;
	logic [31:0] next_offset;
	logic [31:0] image_size_now;
	logic        is_active;
	logic        restart_requested;
	logic [2:0]  writer_action;

	modport source (
		output valid, accepted, update_state, error_code, next_offset, image_size_now,
			is_active, restart_requested, writer_action,
		input  ready
	);
	modport sink (
		input  valid, accepted, update_state, error_code, next_offset, image_size_now,
			is_active, restart_requested, writer_action,
		output ready
	);
endinterface

/* hw/rtl/fwrx_ctrl.sv */
// ----------------------------------------------------------------------------
// fwrx_ctrl: receive sequencer controller
// Takes an event beat, then turns the datapath conditions into update strobes.
// ----------------------------------------------------------------------------
module fwrx_ctrl
	import fwrx_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      evt_valid,
	output logic      evt_ready,
	input  fwrx_sts_t sts,
	output fwrx_cmd_t cmd
);

	typedef enum logic [1:0] {
		CS_IDLE = 2'b01,
		CS_EXEC = 2'b10
	} ctrl_state_t;

	ctrl_state_t state_q, state_d;

	// transfer fails while active: writer gets an abort
	function automatic fwrx_cmd_t fail_xfer(fwrx_cmd_t c_in, err_t e);
		fwrx_cmd_t c;
		c             = c_in;
		c.act         = ACT_ABORT;
		c.set_active  = 1'b1;
		c.active      = 1'b0;
		c.set_restart = 1'b1;
		c.restart     = 1'b0;
		c.set_state   = 1'b1;
		c.state       = ST_FAILED;
		c.set_error   = 1'b1;
		c.error       = e;
		return c;
	endfunction

	// begin refused while idle: state set to failed, size recorded, offset cleared
	function automatic fwrx_cmd_t reject_begin(fwrx_cmd_t c_in, err_t e);
		fwrx_cmd_t c;
		c            = c_in;
		c.set_state  = 1'b1;
		c.state      = ST_FAILED;
		c.set_error  = 1'b1;
		c.error      = e;
		c.load_size  = 1'b1;
		c.clr_offset = 1'b1;
		return c;
	endfunction

	// event decision
	function automatic fwrx_cmd_t decide(fwrx_sts_t s);
		fwrx_cmd_t c;
		c = '0;
		unique case (s.kind)
			KIND_BEGIN: begin
				priority if (s.active) begin
					c.set_error = 1'b1;
					if (s.same_begin) begin
						c.touch = 1'b1;
						c.error = ER_NONE;
						c.acc   = 1'b1;
					end else begin
						c.error = ER_BUSY;
					end
				end else if (s.size_zero || s.size_big) begin
					c = reject_begin(c, s.size_big ? ER_TOO_LARGE : ER_INVALID);
				end else if (!s.wok) begin
					c     = reject_begin(c, ER_WRITE);
					c.act = ACT_BEGIN;
				end else begin
					c.act         = ACT_BEGIN;
					c.set_state   = 1'b1;
					c.state       = ST_RECEIVING;
					c.set_error   = 1'b1;
					c.error       = ER_NONE;
					c.load_size   = 1'b1;
					c.clr_offset  = 1'b1;
					c.load_hash   = 1'b1;
					c.touch       = 1'b1;
					c.set_active  = 1'b1;
					c.active      = 1'b1;
					c.set_restart = 1'b1;
					c.restart     = 1'b0;
					c.acc         = 1'b1;
				end
			end
			KIND_CHUNK: begin
				c.set_error = 1'b1;
				priority if (!s.active) begin
					c.error = ER_NOT_STARTED;
				end else if (s.len_bad || s.end_bad) begin
					c.error = ER_INVALID;
				end else if (s.dup) begin
					c.touch = 1'b1;
					c.error = ER_NONE;
					c.acc   = 1'b1;
				end else if (!s.off_eq) begin
					c.error = ER_OFFSET;
				end else if (!s.wok) begin
					c = fail_xfer(c, ER_WRITE);
				end else begin
					c.act        = ACT_WRITE;
					c.adv_offset = 1'b1;
					c.error      = ER_NONE;
					c.touch      = 1'b1;
					c.acc        = 1'b1;
				end
			end
			KIND_FINISH: begin
				c.set_error = 1'b1;
				priority if (!s.active) begin
					c.error = ER_NOT_STARTED;
				end else if (!s.off_done) begin
					c.touch = 1'b1;
					c.error = ER_INVALID;
				end else if (s.commit != COMMIT_OK) begin
					c       = fail_xfer(c, (s.commit == COMMIT_HASH) ? ER_HASH : ER_WRITE);
					c.touch = 1'b1;
				end else begin
					c.touch       = 1'b1;
					c.act         = ACT_COMMIT;
					c.set_active  = 1'b1;
					c.active      = 1'b0;
					c.set_restart = 1'b1;
					c.restart     = 1'b1;
					c.set_state   = 1'b1;
					c.state       = ST_READY;
					c.error       = ER_NONE;
					c.acc         = 1'b1;
				end
			end
			KIND_TICK: begin
				if (s.active && s.timed_out) begin
					c = fail_xfer(c, ER_TIMEOUT);
				end
			end
			KIND_DISC: begin
				if (s.active) begin
					c = fail_xfer(c, ER_LINK);
				end
			end
			default: begin
				c = '0;
			end
		endcase
		return c;
	endfunction

	// sequencing: take a beat, then evaluate once the result register is free
	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		evt_ready = (state_q == CS_IDLE);
		unique case (state_q)
			CS_IDLE: begin
				if (evt_valid) begin
					cmd.capture = 1'b1;
					state_d     = CS_EXEC;
				end
			end
			CS_EXEC: begin
				if (sts.res_free) begin
					cmd      = decide(sts);
					cmd.exec = 1'b1;
					state_d  = CS_IDLE;
				end
			end
			default: begin
				state_d = CS_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* hw/rtl/fwrx_dp.sv */
// ----------------------------------------------------------------------------
// fwrx_dp: receive sequencer datapath
// Event capture, transfer state, configuration, checks and result register.
// ----------------------------------------------------------------------------
module fwrx_dp
	import fwrx_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [31:0]          cfg_wdata,
	fwrx_evt_if.sink             evt,
	fwrx_res_if.source           res,
	input  fwrx_cmd_t            cmd,
	output fwrx_sts_t            sts
);

	// captured event
	logic [2:0]  kind_q;
	logic [31:0] now_q;
	logic [31:0] size_q;
	logic [63:0] hash_in_q [4];
	logic [31:0] off_q;
	logic [15:0] len_q;
	logic        wok_q;
	logic [1:0]  commit_q;

	// transfer state
	logic        active_q, restart_q;
	upd_state_t  state_q;
	err_t        error_q;
	logic [31:0] size_st_q, exp_off_q, last_q;
	logic [63:0] hash_q [4];

	// configuration
	logic [31:0] max_q, tmo_q;

	// result register
	logic        res_valid_q, res_acc_q, res_active_q, res_restart_q;
	upd_state_t  res_state_q;
	err_t        res_error_q;
	logic [31:0] res_off_q, res_size_q;
	act_t        res_act_q;

	// next values
	logic        active_d, restart_d;
	upd_state_t  state_d;
	err_t        error_d;
	logic [31:0] size_d, off_d;

	logic [32:0] end_sum;
	logic [31:0] elapsed;
	logic        hash_eq;

	// event capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q       <= evt.kind;
			now_q        <= evt.now_ms;
			size_q       <= evt.image_size;
			hash_in_q[0] <= evt.hash_word0;
			hash_in_q[1] <= evt.hash_word1;
			hash_in_q[2] <= evt.hash_word2;
			hash_in_q[3] <= evt.hash_word3;
			off_q        <= evt.chunk_offset;
			len_q        <= evt.chunk_length;
			wok_q        <= evt.writer_ok;
			commit_q     <= evt.commit_result;
		end
	end

	// checks on the captured event
	always_comb begin
		end_sum = {1'b0, off_q} + {17'd0, len_q};
		elapsed = now_q - last_q;
		hash_eq = (hash_in_q[0] == hash_q[0]) && (hash_in_q[1] == hash_q[1]) &&
			(hash_in_q[2] == hash_q[2]) && (hash_in_q[3] == hash_q[3]);

		sts            = '0;
		sts.kind       = kind_q;
		sts.active     = active_q;
		sts.size_zero  = (size_q == '0);
		sts.size_big   = (size_q > max_q);
		sts.same_begin = (size_q == size_st_q) && hash_eq;
		sts.len_bad    = (len_q == '0) || (len_q > 16'(CHUNK_MAX_BYTES));
		sts.end_bad    = end_sum[32] || (end_sum[31:0] > size_st_q);
		sts.dup        = (off_q < exp_off_q) && (end_sum[31:0] <= exp_off_q);
		sts.off_eq     = (off_q == exp_off_q);
		sts.off_done   = (exp_off_q == size_st_q);
		sts.timed_out  = (elapsed > tmo_q);
		sts.wok        = wok_q;
		sts.commit     = commit_q;
		sts.res_free   = !res_valid_q || res.ready;
	end

	// state next values
	always_comb begin
		active_d  = cmd.set_active  ? cmd.active  : active_q;
		restart_d = cmd.set_restart ? cmd.restart : restart_q;
		state_d   = cmd.set_state   ? cmd.state   : state_q;
		error_d   = cmd.set_error   ? cmd.error   : error_q;
		size_d    = cmd.load_size   ? size_q      : size_st_q;
		priority if (cmd.clr_offset) begin
			off_d = '0;
		end else if (cmd.adv_offset) begin
			off_d = end_sum[31:0];
		end else begin
			off_d = exp_off_q;
		end
	end

	// transfer state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			restart_q <= 1'b0;
			state_q   <= ST_IDLE;
			error_q   <= ER_NONE;
			size_st_q <= '0;
			exp_off_q <= '0;
			last_q    <= '0;
			max_q     <= MAX_IMAGE_RST;
			tmo_q     <= TIMEOUT_RST;
		end else begin
			if (cmd.exec) begin
				active_q  <= active_d;
				restart_q <= restart_d;
				state_q   <= state_d;
				error_q   <= error_d;
				size_st_q <= size_d;
				exp_off_q <= off_d;
				if (cmd.touch) begin
					last_q <= now_q;
				end
			end
			if (cfg_we && (cfg_idx == CFG_MAX_IMAGE_BYTES)) begin
				max_q <= cfg_wdata;
			end
			if (cfg_we && (cfg_idx == CFG_INACT_TIMEOUT)) begin
				tmo_q <= cfg_wdata;
			end
		end
	end

	// expected hash, written by a successful begin only
	always_ff @(posedge clk) begin
		if (cmd.exec && cmd.load_hash) begin
			hash_q <= hash_in_q;
		end
	end

	// result beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_acc_q     <= cmd.acc;
			res_state_q   <= state_d;
			res_error_q   <= error_d;
			res_off_q     <= off_d;
			res_size_q    <= size_d;
			res_active_q  <= active_d;
			res_restart_q <= restart_d;
			res_act_q     <= cmd.act;
		end
	end

	assign res.valid             = res_valid_q;
	assign res.accepted          = res_acc_q;
	assign res.update_state      = res_state_q;
	assign res.error_code        = res_error_q;
	assign res.next_offset       = res_off_q;
	assign res.image_size_now    = res_size_q;
	assign res.is_active         = res_active_q;
	assign res.restart_requested = res_restart_q;
	assign res.writer_action     = res_act_q;

endmodule

/* hw/rtl/firmware_image_receive_sequencer.sv */
// ----------------------------------------------------------------------------
// firmware_image_receive_sequencer: image transfer event sequencer, top level
// An event beat is captured, then evaluated into the registered result beat
// once the result register is free; one event is in flight at a time.
// Reset: arst_n clears state and restores config defaults; hash is not reset.
// ----------------------------------------------------------------------------
module firmware_image_receive_sequencer
	import fwrx_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [31:0]          cfg_wdata,
	fwrx_evt_if.sink             evt,
	fwrx_res_if.source           res
);

	fwrx_cmd_t cmd;
	fwrx_sts_t sts;

	// sequencing
	fwrx_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt.valid),
		.evt_ready (evt.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// checks, state and result register
	fwrx_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.evt       (evt),
		.res       (res),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

/* hw/rtl/fwrx_sva.sv */
// ----------------------------------------------------------------------------
// fwrx_sva: receive sequencer port checker
// Watches the event and result channels of the top level.
// ----------------------------------------------------------------------------
`include "firmware_image_receive_sequencer_defines.svh"

module fwrx_sva
	import fwrx_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        evt_valid,
	input logic        evt_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic        res_accepted,
	input logic [2:0]  res_update_state,
	input logic [3:0]  res_error_code,
	input logic        res_is_active,
	input logic        res_restart_requested,
	input logic [2:0]  res_writer_action
);

	// one event in flight: ready drops after a taken beat
	`FWRX_ASSERT_NEXT(a_one_event, clk, arst_n, evt_valid && evt_ready, !evt_ready)

	// a stalled result beat holds
	`FWRX_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_error_code) && $stable(res_writer_action))

	// an accepted event carries no error
	`FWRX_ASSERT_IMPL(a_acc_no_err, clk, arst_n, res_valid && res_accepted, res_error_code == ER_NONE)

	// an active transfer is always receiving
	`FWRX_ASSERT_IMPL(a_active_recv, clk, arst_n, res_valid && res_is_active, res_update_state == ST_RECEIVING)

	// a commit ends the transfer and asks for a restart
	`FWRX_ASSERT_IMPL(a_commit, clk, arst_n, res_valid && (res_writer_action == ACT_COMMIT), res_accepted && res_restart_requested && !res_is_active)

endmodule

bind firmware_image_receive_sequencer fwrx_sva u_fwrx_sva (
	.clk                   (clk),
	.arst_n                (arst_n),
	.evt_valid             (evt.valid),
	.evt_ready             (evt.ready),
	.res_valid             (res.valid),
	.res_ready             (res.ready),
	.res_accepted          (res.accepted),
	.res_update_state      (res.update_state),
	.res_error_code        (res.error_code),
	.res_is_active         (res.is_active),
	.res_restart_requested (res.restart_requested),
	.res_writer_action     (res.writer_action)
);
